/* sv/pes_pkg.sv */
// ----------------------------------------------------------------------------
// pes_pkg : shared definitions for the pitch error statistics block
// Field widths, step counts, the sequencer state type and saturating helpers.
// ----------------------------------------------------------------------------
package pes_pkg;

   localparam int PITCH_W = 16;   // Q12.4 Hz pitch
   localparam int COUNT_W = 21;   // frame counters
   localparam int ERR_W   = 16;   // Q0.16 relative error
   localparam int SUM_W   = 53;   // sum of squared errors
   localparam int SUB_W   = 23;   // shared subtractor width
   localparam int STEP_W  = 6;    // step counter width

   // Iteration counts of the shared unit
   localparam int FRAME_DIV_STEPS = ERR_W;
   localparam int FINAL_DIV_STEPS = SUM_W;
   localparam int ROOT_STEPS      = ERR_W;

   localparam logic [ERR_W-1:0] GROSS_LIMIT_RESET = ERR_W'(13107);
   localparam logic [ERR_W-1:0] ERR_MAX           = '1;

   typedef logic [PITCH_W-1:0] pitch_type;
   typedef logic [COUNT_W-1:0] count_type;
   typedef logic [ERR_W-1:0]   err_type;
   typedef logic [SUM_W-1:0]   sum_type;

   typedef enum logic [7:0] {
      ST_IDLE  = 8'b0000_0001,
      ST_DIV   = 8'b0000_0010,
      ST_CHECK = 8'b0000_0100,
      ST_ACCUM = 8'b0000_1000,
      ST_FINAL = 8'b0001_0000,
      ST_FDIV  = 8'b0010_0000,
      ST_ROOT  = 8'b0100_0000,
      ST_OUT   = 8'b1000_0000
   } state_type;

   // Saturating counter increment
   function automatic count_type sat_inc(input count_type c);
      sat_inc = (c == '1) ? c : c + COUNT_W'(1);
   endfunction

   // Saturating accumulate of one squared error
   function automatic sum_type sat_add(input sum_type s, input logic [2*ERR_W-1:0] p);
      logic [SUM_W:0] t;
      t = {1'b0, s} + (SUM_W+1)'(p);
      sat_add = t[SUM_W] ? '1 : t[SUM_W-1:0];
   endfunction

endpackage

/* sv/pitch_error_statistics.sv */
// ----------------------------------------------------------------------------
// pitch_error_statistics : gross and fine pitch error metrics
// Counts voicing decisions and errors over a sequence of frame pairs and
// reports the counts with the RMS fine relative error on the last frame.
// ----------------------------------------------------------------------------
// Usage:
//  - Request channel (req_*): one reference/estimated pitch pair per request,
//    Q12.4 Hz, zero meaning unvoiced. req_last_frame closes the sequence.
//  - Response channel (rsp_*): one response per sequence, sent after the
//    last frame has been accumulated; all statistics then clear.
//  - csr_wr_en/csr_wr_data set the gross error limit (Q0.16) at any edge.
// Sequence of work (one shared compare/subtract unit under a small sequencer):
//  - frame with a voicing mismatch or unvoiced reference: counted on acceptance
//  - frame voiced on both sides: accept, 16 divide steps, check, add;
//    a gross error skips the add, an error of 1.0 or more skips the divide
//  - last frame adds the final setup, 53 steps of the final divide, 16 root
//    steps and the output state (the root is skipped when it saturates, the
//    divide and root with no fine errors); divide and root share the subtractor.
//  req_ready is high only while the sequencer is idle.
// Reset clears all counters, the sum and the response valid, and restores the
// limit to 0.2. A finished response is held in an output register; if the
// receiver stalls, the next sequence accumulates meanwhile and only the
// following final response waits for the register to empty.
// ----------------------------------------------------------------------------
module pitch_error_statistics (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  pes_pkg::pitch_type  req_ref_pitch,
   input  pes_pkg::pitch_type  req_test_pitch,
   input  logic                req_last_frame,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   output pes_pkg::count_type  rsp_voiced_count,
   output pes_pkg::count_type  rsp_unvoiced_count,
   output pes_pkg::count_type  rsp_voiced_as_unvoiced,
   output pes_pkg::count_type  rsp_unvoiced_as_voiced,
   output pes_pkg::count_type  rsp_both_voiced,
   output pes_pkg::count_type  rsp_gross_count,
   output pes_pkg::err_type    rsp_fine_rms,
   input  logic                csr_wr_en,
   input  pes_pkg::err_type    csr_wr_data
);
   import pes_pkg::*;

   // Control and statistics registers
   state_type state_ff, state_in;
   err_type   limit_ff, limit_in;
   count_type voiced_ff, voiced_in;
   count_type unvoiced_ff, unvoiced_in;
   count_type miss_ff, miss_in;
   count_type false_ff, false_in;
   count_type agree_ff, agree_in;
   count_type gross_ff, gross_in;
   count_type fine_ff, fine_in;
   sum_type   sqsum_ff, sqsum_in;
   logic      rsp_valid_ff, rsp_valid_in;

   // Datapath registers
   logic [SUM_W-1:0]   work_ff, work_in;    // dividend/quotient, root operand
   logic [SUB_W-1:0]   rem_ff, rem_in;      // partial remainder
   count_type          den_ff, den_in;      // divisor
   err_type            root_ff, root_in;
   logic [STEP_W-1:0]  step_ff, step_in;
   logic [2*ERR_W-1:0] prod_ff, prod_in;
   logic               last_ff, last_in;
   err_type            rms_ff, rms_in;
   count_type          o_voiced_ff, o_voiced_in;
   count_type          o_unvoiced_ff, o_unvoiced_in;
   count_type          o_miss_ff, o_miss_in;
   count_type          o_false_ff, o_false_in;
   count_type          o_agree_ff, o_agree_in;
   count_type          o_gross_ff, o_gross_in;
   err_type            o_rms_ff, o_rms_in;

   // Shared compare/subtract unit
   logic [SUB_W-1:0] sub_a, sub_b;
   logic [SUB_W:0]   sub_diff;
   logic             sub_ge;

   // Frame decode
   logic      ref_v, test_v;
   pitch_type pitch_diff;
   err_type   err_val;
   logic      accept;

   assign accept = req_valid && (state_ff == ST_IDLE);
   assign ref_v  = (req_ref_pitch != '0);
   assign test_v = (req_test_pitch != '0);
   assign pitch_diff = (req_ref_pitch > req_test_pitch) ? req_ref_pitch - req_test_pitch
                                                        : req_test_pitch - req_ref_pitch;
   assign err_val = work_ff[ERR_W-1:0];

   // Operand select for the shared unit
   always_comb begin
      sub_a = '0;
      sub_b = '0;
      unique case (state_ff)
         ST_DIV, ST_FDIV: begin
            sub_a = {rem_ff[SUB_W-2:0], work_ff[SUM_W-1]};
            sub_b = SUB_W'(den_ff);
         end
         ST_ROOT: begin
            sub_a = {rem_ff[SUB_W-3:0], work_ff[2*ERR_W-1 -: 2]};
            sub_b = SUB_W'({root_ff, 2'b01});
         end
         default: ;
      endcase
      sub_diff = {1'b0, sub_a} - {1'b0, sub_b};
      sub_ge   = !sub_diff[SUB_W];
   end

   // Sequencer and datapath next state
   always_comb begin
      state_in      = state_ff;
      limit_in      = csr_wr_en ? csr_wr_data : limit_ff;
      voiced_in     = voiced_ff;
      unvoiced_in   = unvoiced_ff;
      miss_in       = miss_ff;
      false_in      = false_ff;
      agree_in      = agree_ff;
      gross_in      = gross_ff;
      fine_in       = fine_ff;
      sqsum_in      = sqsum_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_ready;
      work_in       = work_ff;
      rem_in        = rem_ff;
      den_in        = den_ff;
      root_in       = root_ff;
      step_in       = step_ff;
      prod_in       = prod_ff;
      last_in       = last_ff;
      rms_in        = rms_ff;
      o_voiced_in   = o_voiced_ff;
      o_unvoiced_in = o_unvoiced_ff;
      o_miss_in     = o_miss_ff;
      o_false_in    = o_false_ff;
      o_agree_in    = o_agree_ff;
      o_gross_in    = o_gross_ff;
      o_rms_in      = o_rms_ff;

      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               last_in = req_last_frame;
               // voicing counts
               if (ref_v) voiced_in = sat_inc(voiced_ff);
               else       unvoiced_in = sat_inc(unvoiced_ff);
               if (!ref_v && test_v) false_in = sat_inc(false_ff);
               if (ref_v && !test_v) miss_in = sat_inc(miss_ff);
               if (ref_v && test_v) begin
                  agree_in = sat_inc(agree_ff);
                  if (pitch_diff >= req_ref_pitch) begin
                     // error of 1.0 or more saturates
                     work_in  = SUM_W'(ERR_MAX);
                     state_in = ST_CHECK;
                  end else begin
                     rem_in   = SUB_W'(pitch_diff);
                     den_in   = COUNT_W'(req_ref_pitch);
                     work_in  = '0;
                     step_in  = STEP_W'(FRAME_DIV_STEPS - 1);
                     state_in = ST_DIV;
                  end
               end else if (req_last_frame) begin
                  state_in = ST_FINAL;
               end
            end
         end
         ST_DIV: begin
            // restoring divide step, quotient bits enter at the bottom
            rem_in  = sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
            work_in = {work_ff[SUM_W-2:0], sub_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) state_in = ST_CHECK;
         end
         ST_CHECK: begin
            if (err_val > limit_ff) begin
               gross_in = sat_inc(gross_ff);
               state_in = last_ff ? ST_FINAL : ST_IDLE;
            end else begin
               fine_in  = sat_inc(fine_ff);
               prod_in  = err_val * err_val;
               state_in = ST_ACCUM;
            end
         end
         ST_ACCUM: begin
            sqsum_in = sat_add(sqsum_ff, prod_ff);
            state_in = last_ff ? ST_FINAL : ST_IDLE;
         end
         ST_FINAL: begin
            if (fine_ff == '0) begin
               rms_in   = '0;
               state_in = ST_OUT;
            end else begin
               rem_in   = '0;
               den_in   = fine_ff;
               work_in  = sqsum_ff;
               step_in  = STEP_W'(FINAL_DIV_STEPS - 1);
               state_in = ST_FDIV;
            end
         end
         ST_FDIV: begin
            rem_in  = sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
            work_in = {work_ff[SUM_W-2:0], sub_ge};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               // mean square of 2^32 or more gives a saturated root
               if (work_ff[SUM_W-2:2*ERR_W-1] != '0) begin
                  rms_in   = ERR_MAX;
                  state_in = ST_OUT;
               end else begin
                  rem_in   = '0;
                  root_in  = '0;
                  step_in  = STEP_W'(ROOT_STEPS - 1);
                  state_in = ST_ROOT;
               end
            end
         end
         ST_ROOT: begin
            // digit-by-digit square root, two operand bits per step
            rem_in  = sub_ge ? sub_diff[SUB_W-1:0] : sub_a;
            root_in = {root_ff[ERR_W-2:0], sub_ge};
            work_in = {work_ff[SUM_W-3:0], 2'b00};
            step_in = step_ff - STEP_W'(1);
            if (step_ff == '0) begin
               rms_in   = {root_ff[ERR_W-2:0], sub_ge};
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            // wait for the response register to empty
            if (!rsp_valid_ff || rsp_ready) begin
               o_voiced_in   = voiced_ff;
               o_unvoiced_in = unvoiced_ff;
               o_miss_in     = miss_ff;
               o_false_in    = false_ff;
               o_agree_in    = agree_ff;
               o_gross_in    = gross_ff;
               o_rms_in      = rms_ff;
               rsp_valid_in  = 1'b1;
               voiced_in     = '0;
               unvoiced_in   = '0;
               miss_in       = '0;
               false_in      = '0;
               agree_in      = '0;
               gross_in      = '0;
               fine_in       = '0;
               sqsum_in      = '0;
               state_in      = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Control state and statistics
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         limit_ff     <= GROSS_LIMIT_RESET;
         voiced_ff    <= '0;
         unvoiced_ff  <= '0;
         miss_ff      <= '0;
         false_ff     <= '0;
         agree_ff     <= '0;
         gross_ff     <= '0;
         fine_ff      <= '0;
         sqsum_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         limit_ff     <= limit_in;
         voiced_ff    <= voiced_in;
         unvoiced_ff  <= unvoiced_in;
         miss_ff      <= miss_in;
         false_ff     <= false_in;
         agree_ff     <= agree_in;
         gross_ff     <= gross_in;
         fine_ff      <= fine_in;
         sqsum_ff     <= sqsum_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Datapath and response payload
   always_ff @(posedge clock) begin
      work_ff       <= work_in;
      rem_ff        <= rem_in;
      den_ff        <= den_in;
      root_ff       <= root_in;
      step_ff       <= step_in;
      prod_ff       <= prod_in;
      last_ff       <= last_in;
      rms_ff        <= rms_in;
      o_voiced_ff   <= o_voiced_in;
      o_unvoiced_ff <= o_unvoiced_in;
      o_miss_ff     <= o_miss_in;
      o_false_ff    <= o_false_in;
      o_agree_ff    <= o_agree_in;
      o_gross_ff    <= o_gross_in;
      o_rms_ff      <= o_rms_in;
   end

   // Ports
   assign req_ready              = (state_ff == ST_IDLE);
   assign rsp_valid              = rsp_valid_ff;
   assign rsp_voiced_count       = o_voiced_ff;
   assign rsp_unvoiced_count     = o_unvoiced_ff;
   assign rsp_voiced_as_unvoiced = o_miss_ff;
   assign rsp_unvoiced_as_voiced = o_false_ff;
   assign rsp_both_voiced        = o_agree_ff;
   assign rsp_gross_count        = o_gross_ff;
   assign rsp_fine_rms           = o_rms_ff;

endmodule
